// File: rtl/hte_pkg.sv
// Package for the homogeneous transform engine: word types, op codes,
// controller states and command/status structs. No dependencies.
package hte_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [3:0] {
    OP_IDENTITY  = 4'd0,
    OP_CLEAR     = 4'd1,
    OP_SET       = 4'd2,
    OP_TRANSLATE = 4'd3,
    OP_SCALE     = 4'd4,
    OP_ROTX      = 4'd5,
    OP_ROTY      = 4'd6,
    OP_ROTZ      = 4'd7,
    OP_SHEAR2D   = 4'd8,
    OP_SHEARZ    = 4'd9,
    OP_PERSP     = 4'd10,
    OP_XFORM     = 4'd11,
    OP_READ      = 4'd12,
    OP_TRANSPOSE = 4'd13
  } op_t;

  typedef struct packed {
    logic [3:0]                     op;
    logic signed [WORD_BITS_DEF-1:0] arg_a;
    logic signed [WORD_BITS_DEF-1:0] arg_b;
    logic signed [WORD_BITS_DEF-1:0] arg_c;
    logic signed [WORD_BITS_DEF-1:0] arg_d;
    logic [1:0]                     row_sel;
    logic [1:0]                     col_sel;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_BITS_DEF-1:0] out_x;
    logic signed [WORD_BITS_DEF-1:0] out_y;
    logic signed [WORD_BITS_DEF-1:0] out_z;
    logic signed [WORD_BITS_DEF-1:0] out_w;
    logic                           saturated;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XFORM,
    ST_PREMUL,
    ST_COPY,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;      // capture input word and do the ops applied at load
    logic       xf_step;   // one matrix row times point
    logic       pm_step;   // one element of the premultiplied matrix
    logic       copy;      // temp matrix into main matrix
    logic [3:0] idx;       // row (xform) or element (premultiply)
    logic       out_load;  // latch result word
  } hte_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_xform;
    logic is_read;
    logic is_premul;
  } hte_sts_t;

endpackage

// File: rtl/hte_ctrl.sv
// Controller for the transform engine: sequences xform rows, premultiply
// elements and the result handoff. Uses hte_pkg.
module hte_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  hte_pkg::hte_sts_t sts,
  output hte_pkg::hte_cmd_t cmd
);
  import hte_pkg::*;

  state_t     state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       ovalid, ovalid_next;

  // State, counter and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      ovalid <= ovalid_next;
    end
  end

  assign out_valid = ovalid;
  // Result slot frees when taken; result-producing ops need it free
  logic slot_free;
  assign slot_free = !ovalid || !out_stall;

  // Next state and commands
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    ovalid_next = ovalid && out_stall;
    cmd         = '0;
    cmd.idx     = cnt;
    in_stall    = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_next = '0;
          state_next = ST_XFORM;
        end
      end
      ST_XFORM: begin
        // decode of captured word
        if (sts.is_xform) begin
          cmd.xf_step = 1'b1;
          cnt_next = cnt + 4'd1;
          if (cnt[1:0] == 2'd3) state_next = ST_OUT;
        end else if (sts.is_read) begin
          state_next = ST_OUT;
        end else if (sts.is_premul) begin
          state_next = ST_PREMUL;
          cnt_next = '0;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PREMUL: begin
        cmd.pm_step = 1'b1;
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd15) state_next = ST_COPY;
      end
      ST_COPY: begin
        cmd.copy = 1'b1;
        state_next = ST_IDLE;
      end
      ST_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          ovalid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> state == ST_IDLE) else $error("accept outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_load_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> slot_free) else $error("result overwritten");
  a_copy_after: assert property (@(posedge clk) disable iff (rst)
    cmd.copy |-> $past(cmd.pm_step) && $past(cnt) == 4'd15) else $error("early copy");
`endif
endmodule

// File: rtl/hte_dp.sv
// Datapath for the transform engine: matrix registers, built matrix,
// one shared 4-term dot-product unit, result register. Uses hte_pkg.
module hte_dp #(
  parameter int FRAC_BITS = hte_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  hte_pkg::in_word_t  in_word,
  input  hte_pkg::hte_cmd_t  cmd,
  output hte_pkg::hte_sts_t  sts,
  output hte_pkg::out_word_t out_word
);
  import hte_pkg::*;

  localparam int WORD_BITS = WORD_BITS_DEF;
  localparam int PW = 2 * WORD_BITS;   // product width
  localparam int SW = PW + 2;          // sum of four products
  localparam logic signed [WORD_BITS-1:0] ONE = WORD_BITS'(1) << FRAC_BITS;
  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic signed [WORD_BITS-1:0] m  [16];
  logic signed [WORD_BITS-1:0] t  [16];
  logic signed [WORD_BITS-1:0] bm [16];
  logic signed [WORD_BITS-1:0] bm_next [16];
  logic signed [WORD_BITS-1:0] pt [4];
  logic [3:0]                  op;
  logic [3:0]                  sel;
  logic signed [WORD_BITS-1:0] res [4];
  logic                        flag;

  function automatic logic signed [WORD_BITS-1:0] negs(input logic signed [WORD_BITS-1:0] v);
    negs = (v == WMIN) ? WMAX : -v;
  endfunction

  // Built matrix for the captured op (from the input word as it is accepted)
  logic signed [WORD_BITS-1:0] a, b, c, nb;
  always_comb begin
    a = in_word.arg_a;
    b = in_word.arg_b;
    c = in_word.arg_c;
    nb = negs(b);
    for (int i = 0; i < 16; i++) bm_next[i] = (i % 5 == 0) ? ONE : '0;
    case (op_t'(in_word.op))
      OP_TRANSLATE: begin bm_next[3] = a; bm_next[7] = b; bm_next[11] = c; end
      OP_SCALE:     begin bm_next[0] = a; bm_next[5] = b; bm_next[10] = c; end
      OP_ROTX: begin
        bm_next[5] = a; bm_next[6] = nb; bm_next[9] = b; bm_next[10] = a;
      end
      OP_ROTY: begin
        bm_next[0] = a; bm_next[2] = b; bm_next[8] = nb; bm_next[10] = a;
      end
      OP_ROTZ: begin
        bm_next[0] = a; bm_next[1] = nb; bm_next[4] = b; bm_next[5] = a;
      end
      OP_SHEAR2D: begin bm_next[1] = a; bm_next[4] = b; end
      OP_SHEARZ:  begin bm_next[2] = a; bm_next[6] = b; end
      OP_PERSP:   bm_next[14] = a;
      default: ;
    endcase
  end

  // Shared dot-product unit: four products then sum and clip
  logic signed [WORD_BITS-1:0] da [4];
  logic signed [WORD_BITS-1:0] db [4];
  logic signed [SW-1:0]        sum;
  logic signed [WORD_BITS-1:0] dres;
  logic                        dsat;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (cmd.pm_step) begin
        da[k] = bm[{cmd.idx[3:2], 2'(k)}];
        db[k] = m[{2'(k), cmd.idx[1:0]}];
      end else begin
        da[k] = m[{cmd.idx[1:0], 2'(k)}];
        db[k] = pt[k];
      end
    end
    sum = '0;
    for (int k = 0; k < 4; k++)
      sum = sum + SW'((PW'(da[k]) * PW'(db[k])) >>> FRAC_BITS);
    if (sum > SW'(WMAX)) begin
      dres = WMAX; dsat = 1'b1;
    end else if (sum < SW'(WMIN)) begin
      dres = WMIN; dsat = 1'b1;
    end else begin
      dres = WORD_BITS'(sum); dsat = 1'b0;
    end
  end

  assign sts.is_xform  = (op == OP_XFORM);
  assign sts.is_read   = (op == OP_READ);
  assign sts.is_premul = (op inside {[OP_TRANSLATE:OP_PERSP]});

  // Matrix, built matrix and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_word.op;
      sel <= {in_word.row_sel, in_word.col_sel};
      pt[0] <= a; pt[1] <= b; pt[2] <= c; pt[3] <= in_word.arg_d;
      flag <= 1'b0;
      bm <= bm_next;
      case (op_t'(in_word.op))
        OP_IDENTITY: for (int i = 0; i < 16; i++) m[i] <= (i % 5 == 0) ? ONE : '0;
        OP_CLEAR:    for (int i = 0; i < 16; i++) m[i] <= '0;
        OP_SET:      m[{in_word.row_sel, in_word.col_sel}] <= a;
        OP_TRANSPOSE:
          for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) m[i*4+j] <= m[j*4+i];
        default: ;
      endcase
    end
    if (cmd.xf_step) begin
      res[cmd.idx[1:0]] <= dres;
      flag <= flag | dsat;
    end
    if (cmd.pm_step) t[cmd.idx] <= dres;
    if (cmd.copy) for (int i = 0; i < 16; i++) m[i] <= t[i];
    if (cmd.out_load) begin
      if (op == OP_READ) begin
        out_word.out_x <= m[sel];
        out_word.out_y <= '0; out_word.out_z <= '0; out_word.out_w <= '0;
        out_word.saturated <= 1'b0;
      end else begin
        out_word.out_x <= res[0]; out_word.out_y <= res[1];
        out_word.out_z <= res[2]; out_word.out_w <= res[3];
        out_word.saturated <= flag;
      end
    end
  end
endmodule

// File: rtl/homogeneous_transform_engine.sv
// Top level of the homogeneous 4x4 transform engine.
// Joins hte_ctrl and hte_dp; uses hte_pkg.
//
//   channel   signals                   word
//   in        in_valid, in_stall, in    op, arg_a..arg_d, row_sel, col_sel
//   out       out_valid, out_stall, out out_x..out_w, saturated
//
// Point transform: one matrix row per cycle on the shared dot-product unit, then the
// result handoff. Matrix build ops: one element per cycle, then copy. Identity, clear,
// set, transpose and unused ops finish at load; read goes straight to the result handoff.
// While rst is high the datapath loads the identity matrix; rst clears control.
// A pending result is held in the output register until taken; a new xform or read
// waits for that slot.
module homogeneous_transform_engine #(
  parameter int FRAC_BITS = hte_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hte_pkg::in_word_t  in,
  output logic               out_valid,
  input  logic               out_stall,
  output hte_pkg::out_word_t out
);
  import hte_pkg::*;

  hte_cmd_t cmd;
  hte_sts_t sts;
  hte_cmd_t cmd_dp;
  logic     rst_q;

  // Identity matrix load on reset, issued as a load of the identity op
  in_word_t dp_in;
  always_ff @(posedge clk) rst_q <= rst;
  always_comb begin
    dp_in  = in;
    cmd_dp = cmd;
    if (rst) begin
      dp_in.op   = OP_IDENTITY;
      cmd_dp     = '0;
      cmd_dp.load = 1'b1;
    end
  end

  hte_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  hte_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .in_word(dp_in), .cmd(cmd_dp), .sts, .out_word(out)
  );

`ifndef ASSERT_OFF
  a_no_accept_rst: assert property (@(posedge clk)
    rst_q |-> !cmd.pm_step) else $error("work right after reset");
`endif
endmodule

// File: sim/homogeneous_transform_engine_tb.sv
`timescale 1ns / 100ps
// Testbench for homogeneous_transform_engine: directed table, then random words,
// each result checked against a typed expected value or an in-bench matrix predictor. Depends on hte_pkg.
module homogeneous_transform_engine_tb;
  import hte_pkg::*;

  localparam logic signed [31:0] FX_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] W_MAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] W_MIN  = 32'sh8000_0000;
  localparam logic [3:0] OP_UNUSED_E = 4'd14;
  localparam logic [3:0] OP_UNUSED_F = 4'd15;
  localparam int RANDOM_WORDS = 1450;
  localparam int HOLD_CYCLES  = 200;

  typedef struct {
    in_word_t  cmd;
    bit        typed;
    out_word_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out;

  logic signed [31:0] xfm_mat [16];
  out_word_t          pending_results [$];
  dir_row_t           dir_rows [$];
  int fail_cnt = 0;
  int words_sent = 0;
  int results_seen = 0;
  int xforms_sent = 0;
  int builds_sent = 0;
  bit quiet = 1'b0;
  bit held = 1'b0;

  homogeneous_transform_engine i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in(in),
    .out_valid(out_valid), .out_stall(out_stall), .out(out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("homogeneous_transform_engine test failed");
    $finish;
  end

  // Exact product, low fraction bits dropped toward minus infinity
  function automatic longint fx_prod(logic signed [31:0] x, logic signed [31:0] y);
    longint p;
    p = longint'(x) * longint'(y);
    return p >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp32(longint s, inout bit flag);
    if (s > longint'(W_MAX)) begin
      flag = 1'b1;
      return W_MAX;
    end
    if (s < longint'(W_MIN)) begin
      flag = 1'b1;
      return W_MIN;
    end
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] neg_clip(logic signed [31:0] v);
    return (v == W_MIN) ? W_MAX : -v;
  endfunction

  // Apply one accepted word to the predicted matrix; return any result it gives
  task automatic predict_word(input in_word_t w, output bit has_res, output out_word_t r);
    logic signed [31:0] bm [16];
    logic signed [31:0] nm [16];
    logic signed [31:0] pt [4];
    logic signed [31:0] tmp;
    longint acc;
    bit flag;
    bit build;
    int sel;
    has_res = 1'b0;
    r = '0;
    build = 1'b0;
    flag = 1'b0;
    sel = {w.row_sel, w.col_sel};
    for (int i = 0; i < 16; i++) bm[i] = (i % 5 == 0) ? FX_ONE : '0;
    case (w.op)
      OP_IDENTITY: for (int i = 0; i < 16; i++) xfm_mat[i] = (i % 5 == 0) ? FX_ONE : '0;
      OP_CLEAR:    for (int i = 0; i < 16; i++) xfm_mat[i] = '0;
      OP_SET:      xfm_mat[sel] = w.arg_a;
      OP_TRANSLATE: begin
        bm[3] = w.arg_a; bm[7] = w.arg_b; bm[11] = w.arg_c; build = 1'b1;
      end
      OP_SCALE: begin
        bm[0] = w.arg_a; bm[5] = w.arg_b; bm[10] = w.arg_c; build = 1'b1;
      end
      OP_ROTX: begin
        bm[5] = w.arg_a; bm[6] = neg_clip(w.arg_b); bm[9] = w.arg_b; bm[10] = w.arg_a;
        build = 1'b1;
      end
      OP_ROTY: begin
        bm[0] = w.arg_a; bm[2] = w.arg_b; bm[8] = neg_clip(w.arg_b); bm[10] = w.arg_a;
        build = 1'b1;
      end
      OP_ROTZ: begin
        bm[0] = w.arg_a; bm[1] = neg_clip(w.arg_b); bm[4] = w.arg_b; bm[5] = w.arg_a;
        build = 1'b1;
      end
      OP_SHEAR2D: begin
        bm[1] = w.arg_a; bm[4] = w.arg_b; build = 1'b1;
      end
      OP_SHEARZ: begin
        bm[2] = w.arg_a; bm[6] = w.arg_b; build = 1'b1;
      end
      OP_PERSP: begin
        bm[14] = w.arg_a; build = 1'b1;
      end
      OP_XFORM: begin
        pt[0] = w.arg_a; pt[1] = w.arg_b; pt[2] = w.arg_c; pt[3] = w.arg_d;
        for (int i = 0; i < 4; i++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) acc += fx_prod(xfm_mat[i*4+k], pt[k]);
          pt[i] = pt[i];
          case (i)
            0: r.out_x = clamp32(acc, flag);
            1: r.out_y = clamp32(acc, flag);
            2: r.out_z = clamp32(acc, flag);
            default: r.out_w = clamp32(acc, flag);
          endcase
        end
        r.saturated = flag;
        has_res = 1'b1;
      end
      OP_READ: begin
        r.out_x = xfm_mat[sel];
        has_res = 1'b1;
      end
      OP_TRANSPOSE:
        for (int i = 0; i < 4; i++)
          for (int j = 0; j < i; j++) begin
            tmp = xfm_mat[i*4+j];
            xfm_mat[i*4+j] = xfm_mat[j*4+i];
            xfm_mat[j*4+i] = tmp;
          end
      default: ;
    endcase
    // Premultiply: M <- B * M, clipping silently
    if (build) begin
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) acc += fx_prod(bm[i*4+k], xfm_mat[k*4+j]);
          nm[i*4+j] = clamp32(acc, flag);
        end
      xfm_mat = nm;
      builds_sent++;
    end
  endtask

  function automatic in_word_t mk(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b,
                                  logic signed [31:0] c, logic signed [31:0] d,
                                  logic [1:0] rs, logic [1:0] cs);
    in_word_t w;
    w.op = op; w.arg_a = a; w.arg_b = b; w.arg_c = c; w.arg_d = d;
    w.row_sel = rs; w.col_sel = cs;
    return w;
  endfunction

  function automatic out_word_t res(logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [31:0] z, logic signed [31:0] w, logic s);
    out_word_t r;
    r.out_x = x; r.out_y = y; r.out_z = z; r.out_w = w; r.saturated = s;
    return r;
  endfunction

  function automatic void add_row(in_word_t w, bit typed, out_word_t r);
    dir_row_t row;
    row.cmd = w; row.typed = typed; row.res = r;
    dir_rows.push_back(row);
  endfunction

  function automatic logic signed [31:0] rand_arg();
    case ($urandom_range(0, 9))
      0: case ($urandom_range(0, 4))
           0: return W_MIN;
           1: return W_MAX;
           2: return '0;
           3: return -32'sd1;
           default: return FX_ONE;
         endcase
      1, 2: return $urandom;
      default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh2_0000;
    endcase
  endfunction

  function automatic in_word_t rand_word();
    int r;
    logic [3:0] op;
    r = $urandom_range(0, 99);
    if (r < 40) op = OP_XFORM;
    else if (r < 52) op = OP_READ;
    else if (r < 60) op = OP_SET;
    else if (r < 64) op = OP_IDENTITY;
    else if (r < 65) op = OP_CLEAR;
    else if (r < 67) op = OP_TRANSPOSE;
    else if (r < 69) op = $urandom_range(0, 1) ? OP_UNUSED_E : OP_UNUSED_F;
    else op = 4'($urandom_range(OP_TRANSLATE, OP_PERSP));
    return mk(op, rand_arg(), rand_arg(), rand_arg(), rand_arg(),
              2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
  endfunction

  // Offer one word, hold it until taken, then log its expected result
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    bit has_res;
    out_word_t r;
    in <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_word(w, has_res, r);
    if (has_res) pending_results.push_back(typed ? typed_res : r);
    if (w.op == OP_XFORM) xforms_sent++;
    words_sent++;
    // random gap before the next word
    if (!quiet && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Receiver side: random stall, a quiet window, and one long hold-off
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && words_sent >= 300) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= (!quiet && $urandom_range(0, 99) < 33);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result word x=%h", out.out_x);
        fail_cnt++;
      end else begin
        e = pending_results.pop_front();
        if (out.out_x !== e.out_x) begin
          $error("out_x exp %h got %h", e.out_x, out.out_x); fail_cnt++;
        end
        if (out.out_y !== e.out_y) begin
          $error("out_y exp %h got %h", e.out_y, out.out_y); fail_cnt++;
        end
        if (out.out_z !== e.out_z) begin
          $error("out_z exp %h got %h", e.out_z, out.out_z); fail_cnt++;
        end
        if (out.out_w !== e.out_w) begin
          $error("out_w exp %h got %h", e.out_w, out.out_w); fail_cnt++;
        end
        if (out.saturated !== e.saturated) begin
          $error("saturated exp %b got %b", e.saturated, out.saturated); fail_cnt++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    int counted;
    int guard;
    in_word_t w;
    for (int i = 0; i < 16; i++) xfm_mat[i] = (i % 5 == 0) ? FX_ONE : '0;

    // directed table: extremes, every op, special cases
    add_row(mk(OP_IDENTITY, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0), 1, res(FX_ONE, 0, 0, 0, 0));
    add_row(mk(OP_READ, 0, 0, 0, 0, 3, 2), 1, res(0, 0, 0, 0, 0));
    add_row(mk(OP_XFORM, W_MAX, W_MIN, 1, -1, 0, 0), 1, res(W_MAX, W_MIN, 1, -1, 0));
    // most negative sine: its negation clips to the largest word
    add_row(mk(OP_ROTZ, FX_ONE, W_MIN, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_READ, 0, 0, 0, 0, 0, 1), 1, res(W_MAX, 0, 0, 0, 0));
    add_row(mk(OP_READ, 0, 0, 0, 0, 1, 0), 1, res(W_MIN, 0, 0, 0, 0));
    add_row(mk(OP_XFORM, W_MAX, W_MAX, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_READ, 0, 0, 0, 0, 2, 2), 1, res(0, 0, 0, 0, 0));
    add_row(mk(OP_XFORM, W_MIN, W_MIN, W_MAX, W_MAX, 3, 3), 1, res(0, 0, 0, 0, 0));
    add_row(mk(OP_IDENTITY, 0, 0, 0, 0, 0, 0), 0, '0);
    // build with clipping, twice
    add_row(mk(OP_SCALE, W_MAX, W_MIN, 32'sh2_0000, 0, 0, 0), 0, '0);
    add_row(mk(OP_SCALE, W_MAX, W_MIN, 32'sh2_0000, 0, 0, 0), 0, '0);
    add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_READ, 0, 0, 0, 0, 1, 1), 0, '0);
    add_row(mk(OP_SET, 32'shdead_beef, 0, 0, 0, 3, 3), 0, '0);
    add_row(mk(OP_SET, 32'sh0003_8000, 0, 0, 0, 0, 3), 0, '0);
    add_row(mk(OP_TRANSPOSE, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_READ, 0, 0, 0, 0, 3, 0), 0, '0);
    add_row(mk(OP_IDENTITY, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_TRANSLATE, 32'sh5_0000, -32'sh3_0000, 32'sh0_8000, 0, 0, 0), 0, '0);
    add_row(mk(OP_ROTX, 32'sh0_b505, 32'sh0_b505, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_ROTY, 32'sh0_ddb4, -32'sh0_8000, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_SHEAR2D, 32'sh0_4000, -32'sh0_2000, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_SHEARZ, -32'sh1_0000, 32'sh0_1000, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_PERSP, 32'sh0_0400, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(OP_UNUSED_E, W_MAX, W_MAX, W_MAX, W_MAX, 3, 3), 0, '0);
    add_row(mk(OP_UNUSED_F, W_MIN, W_MIN, W_MIN, W_MIN, 0, 0), 0, '0);
    add_row(mk(OP_XFORM, 32'sh1_0000, 32'sh2_0000, -32'sh3_0000, 32'sh1_0000, 0, 0), 0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);

    counted = 0;
    while (counted < RANDOM_WORDS) begin
      quiet = (counted >= 700 && counted < 900);
      w = rand_word();
      send_word(w, 0, '0);
      if (w.op != OP_UNUSED_E && w.op != OP_UNUSED_F) counted++;
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_cnt++;
    end

    $display("Sent %0d words (%0d point transforms, %0d matrix builds), checked %0d results.",
             words_sent, xforms_sent, builds_sent, results_seen);
    if (fail_cnt == 0) begin
      $display("homogeneous_transform_engine test passed");
    end else begin
      $display("homogeneous_transform_engine test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/hte_pkg.sv
rtl/hte_ctrl.sv
rtl/hte_dp.sv
rtl/homogeneous_transform_engine.sv
sim/homogeneous_transform_engine_tb.sv
